>>> hdl/bounded_list_shift_store_top_assert.svh
// assertion macros shared by the list control and top level
`ifndef BOUNDED_LIST_SHIFT_STORE_TOP_ASSERT_SVH
`define BOUNDED_LIST_SHIFT_STORE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bls_pkg.sv
// shared types and constants for the bounded list
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
        logic rd_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/bls_cell.sv
// one list entry cell: holds an entry, appends or shifts down from its neighbor
`timescale 1ns / 1ps
`default_nettype none

module bls_cell
    import bls_pkg::*;
#(
    parameter int POS        = 0,
    parameter int ELEM_WIDTH = 32,
    parameter int CMP_W      = 6
)
(
    input  wire logic                  clk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [CMP_W-1:0]      index_ext,
    input  wire logic [CMP_W-1:0]      count_cur,
    input  wire logic [CMP_W-1:0]      count_nxt,
    input  wire logic [ELEM_WIDTH-1:0] value_elem,
    input  wire logic [ELEM_WIDTH-1:0] right_data,
    output logic      [ELEM_WIDTH-1:0] data,
    output logic      [ELEM_WIDTH-1:0] data_nxt,
    output logic      [ELEM_WIDTH-1:0] rd_tap,
    output logic      [ELEM_WIDTH-1:0] last_tap
);

    localparam logic [CMP_W-1:0] POS_EXT  = CMP_W'(POS);
    localparam logic [CMP_W-1:0] TAIL_CNT = CMP_W'(POS + 1);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    always_comb
    begin
        if (ctrl.ins_en && (POS_EXT == count_cur))
        begin
            data_next = value_elem;
        end
        else if (ctrl.rem_en && (POS_EXT >= index_ext))
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign data_nxt = data_next;
    assign rd_tap   = (POS_EXT == index_ext) ? data_reg : '0;
    assign last_tap = (TAIL_CNT == count_nxt) ? data_next : '0;

endmodule

`default_nettype wire

>>> hdl/bls_ctrl.sv
// list control: entry count, operation decode and status
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_list_shift_store_top_assert.svh"

module bls_ctrl
    import bls_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CNT_W = 5,
    parameter int CMP_W = 6
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic [INDEX_W-1:0] index,
    output cell_ctrl_t              ctrl,
    output status_t                 status,
    output logic      [CMP_W-1:0]   index_ext,
    output logic      [CMP_W-1:0]   count_cur,
    output logic      [CMP_W-1:0]   count_nxt
);

    localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             idx_in_range;
    logic             is_full;
    logic             is_empty;

    assign index_ext    = CMP_W'(index);
    assign count_cur    = CMP_W'(count_reg);
    assign count_nxt    = CMP_W'(count_next);
    assign idx_in_range = index_ext < count_cur;
    assign is_full      = count_cur == FULL_CNT;
    assign is_empty     = count_reg == '0;

    always_comb
    begin
        status     = ST_OK;
        ctrl       = '0;
        count_next = count_reg;
        unique case (mode_t'(mode))
            MODE_INSERT:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    ctrl.ins_en = accept;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else if (!idx_in_range)
                begin
                    status = ST_BAD_INDEX;
                end
                else
                begin
                    ctrl.rem_en = accept;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            MODE_READ:
            begin
                if (!idx_in_range)
                begin
                    status = ST_BAD_INDEX;
                end
                else
                begin
                    ctrl.rd_en = accept;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    `BLS_ASSERT_NOW(a_count_bound, 1'b1, count_cur <= FULL_CNT, "entry count above capacity")
    `BLS_ASSERT_NEXT(a_full_hold, accept && (status == ST_FULL), $stable(count_reg), "count moved on full insert")
    `BLS_ASSERT_NEXT(a_remove_dec, ctrl.rem_en, count_reg == $past(count_reg) - CNT_W'(1), "remove did not lower count")

endmodule

`default_nettype wire

>>> hdl/bounded_list_shift_store_top.sv
// bounded list top level: cell chain, control and output register
//
// usage
//   input channel (in_valid/in_ready) carries one word: mode, index, value.
//   mode insert appends value, remove deletes the entry at index and shifts
//   later entries down, read returns the entry at index.
//   output channel (out_valid/out_ready) carries one result word per input
//   word: status, read_value, count, is_empty, first_value, last_value.
//   the result is presented in the cycle after the input word is taken.
//   throughput: one word per cycle unless stalled; every entry lives in its
//   own cell, so an append or a shift of all later entries ends on accept.
//   stall: the result sits in the output register; in_ready stays low while a
//   result waits and out_ready is low, and rises again once it is taken.
//   reset: the list is emptied (count zero) and no result is pending; entry
//   cells are not cleared, only entries below the count are ever read.
//   first_value and last_value read as zero while the list is empty.
//
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_list_shift_store_top_assert.svh"

module bounded_list_shift_store_top
    import bls_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic [INDEX_W-1:0] index,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [1:0]         status,
    output logic      [VALUE_W-1:0] read_value,
    output logic      [COUNT_W-1:0] count,
    output logic                    is_empty,
    output logic      [VALUE_W-1:0] first_value,
    output logic      [VALUE_W-1:0] last_value
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    logic                  accept;
    cell_ctrl_t            ctrl;
    status_t               op_status;
    logic [CMP_W-1:0]      index_ext;
    logic [CMP_W-1:0]      count_cur;
    logic [CMP_W-1:0]      count_nxt;
    logic [ELEM_WIDTH-1:0] value_elem;

    logic [ELEM_WIDTH-1:0] cell_q    [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_d    [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_taps   [DEPTH];
    logic [ELEM_WIDTH-1:0] last_taps [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_sel;
    logic [ELEM_WIDTH-1:0] last_sel;

    logic               out_valid_reg;
    status_t            status_reg;
    logic [VALUE_W-1:0] read_value_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               is_empty_reg;
    logic [VALUE_W-1:0] first_value_reg;
    logic [VALUE_W-1:0] last_value_reg;

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign value_elem = ELEM_WIDTH'(value);

    bls_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .CMP_W (CMP_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (mode),
        .index     (index),
        .ctrl      (ctrl),
        .status    (op_status),
        .index_ext (index_ext),
        .count_cur (count_cur),
        .count_nxt (count_nxt)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] right_data;

        if (i < DEPTH - 1)
        begin : g_mid
            assign right_data = cell_q[i + 1];
        end
        else
        begin : g_end
            assign right_data = cell_q[i];
        end

        bls_cell #(
            .POS        (i),
            .ELEM_WIDTH (ELEM_WIDTH),
            .CMP_W      (CMP_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .index_ext  (index_ext),
            .count_cur  (count_cur),
            .count_nxt  (count_nxt),
            .value_elem (value_elem),
            .right_data (right_data),
            .data       (cell_q[i]),
            .data_nxt   (cell_d[i]),
            .rd_tap     (rd_taps[i]),
            .last_tap   (last_taps[i])
        );
    end

    always_comb
    begin
        rd_sel   = '0;
        last_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_sel   = rd_sel | rd_taps[i];
            last_sel = last_sel | last_taps[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= op_status;
            read_value_reg  <= ctrl.rd_en ? VALUE_W'(rd_sel) : '0;
            count_reg       <= COUNT_W'(count_nxt);
            is_empty_reg    <= count_nxt == '0;
            first_value_reg <= (count_nxt == '0) ? '0 : VALUE_W'(cell_d[0]);
            last_value_reg  <= VALUE_W'(last_sel);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign count       = count_reg;
    assign is_empty    = is_empty_reg;
    assign first_value = first_value_reg;
    assign last_value  = last_value_reg;

    `BLS_ASSERT_NOW(a_empty_ends, out_valid_reg && is_empty_reg,
        (first_value_reg == '0) && (last_value_reg == '0), "nonzero ends on empty list")
    `BLS_ASSERT_NOW(a_empty_status, out_valid_reg && (status_reg == ST_EMPTY),
        is_empty_reg, "empty status on nonempty list")
    `BLS_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ready,
        out_valid_reg && $stable(status_reg), "result word changed while stalled")

endmodule

`default_nettype wire

>>> bench/tb_bounded_list_shift_store_top.sv
// testbench for the bounded list: drives list operations and checks every result word
`timescale 1ns / 1ps

module tb_bounded_list_shift_store_top;
    import bls_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int ELEM_W      = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_STALL  = 300;
    localparam int TAIL_CYCLES = 8;
    localparam int RAND_WORDS  = 1475;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]  op;
        logic [INDEX_W-1:0] pos;
        logic [VALUE_W-1:0] val;
        int                 gap;
        bit                 pause;
    } list_word_t;

    typedef struct {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] last_value;
    } list_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  mode = '0;
    logic [INDEX_W-1:0] index = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] last_value;

    list_word_t   stim_words[$];
    list_result_t list_results_due[$];
    logic [ELEM_W-1:0] list_copy [LIST_DEPTH];
    int           list_len = 0;
    int           gen_len = 0;
    int           hold_left = 0;
    int           rx_hold = 0;
    int           taken_cnt = 0;
    int           words_taken = 0;
    int           results_seen = 0;
    int           mismatch_cnt = 0;
    int           status_hits [4] = '{0, 0, 0, 0};
    int           cycle_cnt = 0;
    logic         feed_done = 1'b0;
    logic         results_clear = 1'b1;

    bounded_list_shift_store_top #(
        .DEPTH      (LIST_DEPTH),
        .ELEM_WIDTH (ELEM_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .index       (index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .count       (count),
        .is_empty    (is_empty),
        .first_value (first_value),
        .last_value  (last_value)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic list_result_t apply_list_op(logic [MODE_W-1:0] op,
                                                   logic [INDEX_W-1:0] pos,
                                                   logic [VALUE_W-1:0] val);
        list_result_t r;
        int           i;
        r.status     = ST_OK;
        r.read_value = '0;
        if (op == MODE_INSERT)
        begin
            if (list_len >= LIST_DEPTH)
                r.status = ST_FULL;
            else
            begin
                list_copy[list_len] = val;
                list_len++;
            end
        end
        else if (op == MODE_REMOVE)
        begin
            if (list_len == 0)
                r.status = ST_EMPTY;
            else if (int'(pos) >= list_len)
                r.status = ST_BAD_INDEX;
            else
            begin
                for (i = int'(pos); i + 1 < list_len; i++)
                    list_copy[i] = list_copy[i + 1];
                list_len--;
            end
        end
        else if (op == MODE_READ)
        begin
            if (int'(pos) >= list_len)
                r.status = ST_BAD_INDEX;
            else
                r.read_value = list_copy[pos];
        end
        r.count       = list_len[COUNT_W-1:0];
        r.is_empty    = (list_len == 0);
        r.first_value = (list_len == 0) ? '0 : list_copy[0];
        r.last_value  = (list_len == 0) ? '0 : list_copy[list_len - 1];
        return r;
    endfunction

    function automatic int draw_tx_gap(int k);
        if ((k / 200) % 3 == 2)
            return 0;
        return ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 18);
    endfunction

    task automatic push_word(logic [MODE_W-1:0] op, logic [INDEX_W-1:0] pos,
                             logic [VALUE_W-1:0] val);
        list_word_t w;
        w.op    = op;
        w.pos   = pos;
        w.val   = val;
        w.gap   = draw_tx_gap(stim_words.size());
        w.pause = 1'b0;
        stim_words.push_back(w);
        if (op == MODE_INSERT && gen_len < LIST_DEPTH)
            gen_len++;
        else if (op == MODE_REMOVE && gen_len > 0 && int'(pos) < gen_len)
            gen_len--;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    // input side: one word at a time from the stimulus queue
    always @(posedge clk)
    begin : word_feed
        list_word_t nxt;
        logic       offer;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            mode      <= MODE_INSERT;
            index     <= '0;
            value     <= '0;
            feed_done <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && in_ready)
            begin
                offer = 1'b0;
                words_taken++;
            end
            if (!offer)
            begin
                if (hold_left > 0)
                    hold_left--;
                else if (stim_words.size() != 0)
                begin
                    if (stim_words[0].pause)
                    begin
                        // hold until every result word is back
                        if (!in_valid && results_clear)
                            nxt = stim_words.pop_front();
                    end
                    else
                    begin
                        nxt = stim_words.pop_front();
                        mode      <= nxt.op;
                        index     <= nxt.pos;
                        value     <= nxt.val;
                        hold_left = nxt.gap;
                        offer     = 1'b1;
                    end
                end
            end
            in_valid  <= offer;
            feed_done <= !offer && (stim_words.size() == 0);
        end
    end

    // output side: random back-pressure plus two long holds
    always @(posedge clk)
    begin : result_sink
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                taken_cnt++;
                if (taken_cnt == 400 || taken_cnt == 1100)
                    rx_hold = LONG_STALL;
                else if ((taken_cnt / 200) % 3 == 1)
                    rx_hold = 0;
                else
                    rx_hold = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 18);
            end
            else if (rx_hold > 0)
                rx_hold--;
            out_ready <= (rx_hold == 0);
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (list_results_due.size() == 0)
                begin
                    $error("result word with no expected result");
                    mismatch_cnt++;
                end
                else
                begin
                    want = list_results_due.pop_front();
                    status_hits[want.status]++;
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("read_value", want.read_value, read_value);
                    check_field("count", 32'(want.count), 32'(count));
                    check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
                    check_field("first_value", want.first_value, first_value);
                    check_field("last_value", want.last_value, last_value);
                end
            end
            if (in_valid && in_ready)
                list_results_due.push_back(apply_list_op(mode, index, value));
            results_clear <= (list_results_due.size() == 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : run_ctrl
        list_word_t         hold_word;
        int                 useful;
        int                 k;
        int                 pick;
        int                 ins_pct;
        int                 rem_pct;
        logic [MODE_W-1:0]  op;
        logic [INDEX_W-1:0] pos;
        logic [VALUE_W-1:0] val;

        // empty list corner cases
        push_word(MODE_READ, 6'd0, 32'h0);
        push_word(MODE_REMOVE, 6'd5, 32'h0);
        push_word(MODE_UNUSED, 6'd63, 32'hFFFF_FFFF);
        // fill to capacity, then one past it
        for (k = 0; k < LIST_DEPTH; k++)
        begin
            if (k == 0)
                val = 32'hFFFF_FFFF;
            else if (k == 1)
                val = 32'h0;
            else
                val = $urandom;
            push_word(MODE_INSERT, 6'($urandom_range(0, 63)), val);
        end
        push_word(MODE_INSERT, 6'd0, 32'hA5A5_5A5A);
        push_word(MODE_READ, 6'd15, 32'h0);
        push_word(MODE_READ, 6'd16, 32'h0);
        push_word(MODE_READ, 6'd63, 32'h0);
        push_word(MODE_REMOVE, 6'd63, 32'h0);
        push_word(MODE_REMOVE, 6'd15, 32'h0);
        push_word(MODE_REMOVE, 6'd0, 32'h0);

        useful = 0;
        while (useful < RAND_WORDS)
        begin
            if (useful == 700 || useful == 1200)
            begin
                hold_word.op    = MODE_INSERT;
                hold_word.pos   = '0;
                hold_word.val   = '0;
                hold_word.gap   = 0;
                hold_word.pause = 1'b1;
                stim_words.push_back(hold_word);
            end
            // alternate fill-heavy and drain-heavy stretches
            ins_pct = ((useful / 120) % 2 == 0) ? 55 : 25;
            rem_pct = ((useful / 120) % 2 == 0) ? 20 : 45;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = MODE_UNUSED;
            else if (pick < 3 + ins_pct)
                op = MODE_INSERT;
            else if (pick < 3 + ins_pct + rem_pct)
                op = MODE_REMOVE;
            else
                op = MODE_READ;
            if (gen_len > 0 && $urandom_range(0, 9) < 8)
                pos = 6'($urandom_range(0, gen_len - 1));
            else
                pos = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 9))
                0:       val = 32'h0;
                1:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            push_word(op, pos, val);
            if (op != MODE_UNUSED)
                useful++;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (!(feed_done && results_clear))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (list_results_due.size() != 0)
        begin
            $error("%0d expected results never arrived", list_results_due.size());
            mismatch_cnt++;
        end
        $display("%0d words sent and %0d result words compared, with two long output holds",
                 words_taken, results_seen);
        $display("status seen: ok %0d, bad index %0d, empty %0d, full %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_INDEX],
                 status_hits[ST_EMPTY], status_hits[ST_FULL]);
        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
